// File: src/kli_pkg.sv
`default_nettype none
package kli_pkg;

  typedef struct packed {
    logic               func;
    logic [5:0]         key_index;
    logic [23:0]        sample_time;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [5:0]         segment;
    logic               factor_forced;
  } out_item_t;

  typedef struct packed {
    logic [23:0] key_time;
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic [31:0] key_z;
  } key_t;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam int unsigned FracBits = 16;
  localparam int unsigned QuoBits  = 17;

endpackage
`default_nettype wire

// File: src/keyframe_linear_interpolator.sv
// Sequence: a key write is taken in S_IDLE and gives no item; a query steps
//   through S_SCAN_RD and S_SCAN_CMP per key compared (at most MAX_KEYS-1
//   keys), S_LOAD_A to S_LOAD_C, the bit-serial divider only when the factor
//   needs a division, S_MUL and S_ADD per component, and S_DONE; a single key
//   skips the scan. Throughput: one query at a time, held until S_DONE
//   hands the result on. Writes are taken every cycle while idle.
// Reset: rst_ni clears the sequencer, the output valid and sets key_count to 1.
`default_nettype none
module keyframe_linear_interpolator #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [6:0]        cfg_data,
  input  wire               in_valid,
  output logic              in_ready,
  input  kli_pkg::in_item_t in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output kli_pkg::out_item_t out_data
);

  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_SCAN_RD  = 10'b0000000010,
    S_SCAN_CMP = 10'b0000000100,
    S_LOAD_A   = 10'b0000001000,
    S_LOAD_B   = 10'b0000010000,
    S_LOAD_C   = 10'b0000100000,
    S_DIV      = 10'b0001000000,
    S_MUL      = 10'b0010000000,
    S_ADD      = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [6:0]   key_count_q;
  logic [23:0]  t_q;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] seg_q, seg_d;
  logic          single_q, single_d;
  logic          forced_q, forced_d;
  kli_pkg::key_t start_q, end_q, rd_q;
  logic [24:0]  rem_q;
  logic [23:0]  aspan_q;
  logic [kli_pkg::QuoBits-1:0] quo_q;
  logic [4:0]   cnt_q;
  logic [1:0]   comp_q;
  logic signed [50:0] prod_q;
  logic [31:0]  res_q [3];
  logic         out_valid_q;
  kli_pkg::out_item_t out_q;

  kli_pkg::key_t mem [MAX_KEYS];
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [31:0]   idx_ext;
  logic [31:0]   n32;
  logic [CW-1:0] n_keys;
  logic [CW:0]   scan_next;

  // Clamp key count into 1..MAX_KEYS
  always_comb begin
    if (key_count_q == 7'd0) begin
      n32 = 32'd1;
    end else if (32'(key_count_q) > MAX_KEYS) begin
      n32 = MAX_KEYS;
    end else begin
      n32 = 32'(key_count_q);
    end
  end
  assign n_keys    = n32[CW-1:0];
  assign scan_next = (CW+1)'(idx_q) + (CW+1)'(2);

  assign idx_ext   = 32'(in_data.key_index);
  assign in_ready  = (state_q == S_IDLE);
  assign cfg_ready = 1'b1;
  assign wr_en     = in_valid && in_ready && (in_data.func == kli_pkg::FUNC_WRITE)
                     && (idx_ext < MAX_KEYS);

  // Key table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx_ext[AW-1:0]] <= '{key_time: in_data.sample_time,
                                key_x: in_data.value_x,
                                key_y: in_data.value_y,
                                key_z: in_data.value_z};
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    case (state_q)
      S_SCAN_RD: rd_addr = idx_q + AW'(1);
      S_LOAD_A:  rd_addr = seg_q;
      S_LOAD_B:  rd_addr = seg_q + AW'(1);
      default:   rd_addr = '0;
    endcase
  end

  // Factor setup from the two segment keys
  logic [24:0] num, span;
  logic [23:0] anum, aspan;
  logic        need_div, setup_forced;
  always_comb begin
    num   = {1'b0, t_q} - {1'b0, start_q.key_time};
    span  = {1'b0, rd_q.key_time} - {1'b0, start_q.key_time};
    anum  = num[24] ? 24'(-num) : num[23:0];
    aspan = span[24] ? 24'(-span) : span[23:0];
    need_div     = 1'b0;
    setup_forced = 1'b0;
    if (!single_q) begin
      if (span == '0) begin
        setup_forced = 1'b1;
      end else if (num != '0) begin
        if ((num[24] != span[24]) || (anum > aspan)) begin
          setup_forced = 1'b1;
        end else begin
          need_div = 1'b1;
        end
      end
    end
  end

  // Divider step
  logic        div_ge;
  logic [24:0] div_rem;
  assign div_ge  = rem_q >= {1'b0, aspan_q};
  assign div_rem = rem_q - (div_ge ? {1'b0, aspan_q} : 25'd0);

  // Shared multiplier operands
  logic [31:0] mul_a, mul_b;
  logic signed [32:0] mul_diff;
  always_comb begin
    case (comp_q)
      2'd0:    begin mul_a = start_q.key_x; mul_b = end_q.key_x; end
      2'd1:    begin mul_a = start_q.key_y; mul_b = end_q.key_y; end
      default: begin mul_a = start_q.key_z; mul_b = end_q.key_z; end
    endcase
    mul_diff = $signed({mul_b[31], mul_b}) - $signed({mul_a[31], mul_a});
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    seg_d    = seg_q;
    single_d = single_q;
    forced_d = forced_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid && (in_data.func == kli_pkg::FUNC_QUERY)) begin
          idx_d    = '0;
          seg_d    = '0;
          forced_d = 1'b0;
          single_d = (n_keys == CW'(1));
          state_d  = (n_keys == CW'(1)) ? S_LOAD_A : S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (t_q < rd_q.key_time) begin
          seg_d   = idx_q;
          state_d = S_LOAD_A;
        end else if (scan_next >= (CW+1)'(n_keys)) begin
          seg_d   = '0;
          state_d = S_LOAD_A;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_LOAD_A: state_d = S_LOAD_B;
      S_LOAD_B: state_d = S_LOAD_C;
      S_LOAD_C: begin
        forced_d = setup_forced;
        state_d  = need_div ? S_DIV : S_MUL;
      end
      S_DIV:   if (cnt_q == 5'(kli_pkg::QuoBits - 1)) state_d = S_MUL;
      S_MUL:   state_d = S_ADD;
      S_ADD:   state_d = (comp_q == 2'd2) ? S_DONE : S_MUL;
      S_DONE:  if (!out_valid_q || out_ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_count_q <= 7'd1;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      seg_q       <= '0;
      single_q    <= 1'b0;
      forced_q    <= 1'b0;
      cnt_q       <= '0;
      comp_q      <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      seg_q    <= seg_d;
      single_q <= single_d;
      forced_q <= forced_d;
      if (cfg_valid) begin
        key_count_q <= cfg_data;
      end
      // Hold the result until taken
      if ((state_q == S_DONE) && (!out_valid_q || out_ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD_C: begin
          cnt_q  <= '0;
          comp_q <= '0;
        end
        S_DIV:   cnt_q  <= cnt_q + 5'd1;
        S_ADD:   comp_q <= comp_q + 2'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      t_q <= in_data.sample_time;
    end
    case (state_q)
      S_LOAD_B: start_q <= rd_q;
      S_LOAD_C: begin
        end_q   <= rd_q;
        rem_q   <= {1'b0, anum};
        aspan_q <= aspan;
        quo_q   <= '0;
      end
      S_DIV: begin
        rem_q <= {div_rem[23:0], 1'b0};
        quo_q <= {quo_q[kli_pkg::QuoBits-2:0], div_ge};
      end
      S_MUL: begin
        // Pass key 0 through untouched with a single key
        if (single_q) begin
          prod_q <= '0;
        end else begin
          prod_q <= mul_diff * $signed({1'b0, quo_q});
        end
      end
      S_ADD: res_q[comp_q] <= mul_a + prod_q[kli_pkg::FracBits+31:kli_pkg::FracBits];
      S_DONE: begin
        if (!out_valid_q || out_ready) begin
          out_q.out_x         <= res_q[0];
          out_q.out_y         <= res_q[1];
          out_q.out_z         <= res_q[2];
          out_q.segment       <= 6'(seg_q);
          out_q.factor_forced <= forced_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_q;
  assign out_data  = out_q;

endmodule
`default_nettype wire

// File: src/kli_checker.sv
`default_nettype none
module kli_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid,
  input wire               in_ready,
  input kli_pkg::in_item_t in_data,
  input wire               out_valid,
  input wire               out_ready,
  input kli_pkg::out_item_t out_data
);

  // A query holds off the next item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_data.func == kli_pkg::FUNC_QUERY) |=> !in_ready)
    else $error("input taken right after a query");

  // A key write leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_data.func == kli_pkg::FUNC_WRITE) |=> in_ready)
    else $error("not ready after a key write");

  // A new result appears as the block returns to ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while busy");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind keyframe_linear_interpolator kli_checker u_kli_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
